// ----- sv/tat_pkg.sv -----
`default_nettype none
package tat_pkg;

   localparam int LOG_FRAC = 28;
   localparam int MANT_W = 31;
   localparam int ACC_W = 32;
   localparam int DEN_W = 46;
   localparam int DIVIDEND_W = 62;
   localparam int QUOT_W = 18;
   localparam int TEMP_W = 17;

   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic signed [TEMP_W-1:0] OUT_MAX = 17'sd60000;
   localparam logic signed [TEMP_W-1:0] OUT_COLD = -17'sd27315;
   localparam logic [TEMP_W-1:0] ZERO_C_CK = 17'd27315;
   localparam logic [QUOT_W-1:0] Q_MAX = 18'd87315;

   localparam logic [13:0] BETA_RESET = 14'd3950;
   localparam logic [15:0] T0_RESET = 16'd29815;

   typedef enum logic [0:0] {
      CSR_BETA = 1'b0,
      CSR_NOMINAL_TEMP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic special;
      logic [MANT_W-1:0] m_c;
      logic [MANT_W-1:0] m_r;
      logic [ACC_W-1:0] acc_c;
      logic [ACC_W-1:0] acc_r;
   } log_type;

   typedef struct packed {
      logic special;
      logic sat;
      logic [DIVIDEND_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUOT_W-1:0] q;
   } div_type;

endpackage
`default_nettype wire

// ----- sv/tat_if.sv -----
`default_nettype none
interface tat_req_if #(parameter int ADC_BITS = 12) ();
   logic valid;
   logic ready;
   logic [ADC_BITS-1:0] adc_code;
   modport source (output valid, output adc_code, input ready);
   modport sink (input valid, input adc_code, output ready);
endinterface

interface tat_rsp_if ();
   logic valid;
   logic ready;
   logic signed [16:0] temp_centi_celsius;
   logic temp_valid;
   modport source (output valid, output temp_centi_celsius, output temp_valid, input ready);
   modport sink (input valid, input temp_centi_celsius, input temp_valid, output ready);
endinterface
`default_nettype wire

// ----- sv/tat_log2_step.sv -----
`default_nettype none
module tat_log2_step #(
   parameter int BIT = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic up_valid,
   output logic up_ready,
   input  tat_pkg::log_type up_data,
   output logic dn_valid,
   input  wire logic dn_ready,
   output tat_pkg::log_type dn_data
);
   import tat_pkg::*;

   logic valid_ff;
   log_type data_ff, data_in;
   logic [2*MANT_W-1:0] sq_c, sq_r;
   logic [MANT_W:0] t_c, t_r;

   assign up_ready = ~valid_ff | dn_ready;

   // One fraction bit per stage: square the mantissa, and a value of two or
   // more sets the bit and halves the mantissa back into range.
   always_comb begin
      sq_c = up_data.m_c * up_data.m_c;
      sq_r = up_data.m_r * up_data.m_r;
      t_c = sq_c[2*MANT_W-1:MANT_W-1];
      t_r = sq_r[2*MANT_W-1:MANT_W-1];
      data_in = up_data;
      if (t_c[MANT_W]) begin
         data_in.m_c = t_c[MANT_W:1];
         data_in.acc_c = up_data.acc_c + (ACC_W'(1) << BIT);
      end else begin
         data_in.m_c = t_c[MANT_W-1:0];
      end
      if (t_r[MANT_W]) begin
         data_in.m_r = t_r[MANT_W:1];
         data_in.acc_r = up_data.acc_r + (ACC_W'(1) << BIT);
      end else begin
         data_in.m_r = t_r[MANT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data = data_ff;
endmodule
`default_nettype wire

// ----- sv/tat_div_step.sv -----
`default_nettype none
module tat_div_step #(
   parameter int SHIFT = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic up_valid,
   output logic up_ready,
   input  tat_pkg::div_type up_data,
   output logic dn_valid,
   input  wire logic dn_ready,
   output tat_pkg::div_type dn_data
);
   import tat_pkg::*;

   logic valid_ff;
   div_type data_ff, data_in;
   logic [63:0] trial;
   logic hit;

   assign up_ready = ~valid_ff | dn_ready;

   always_comb begin
      trial = 64'(up_data.den) << SHIFT;
      hit = 64'(up_data.rem) >= trial;
      data_in = up_data;
      if (hit) begin
         data_in.rem = DIVIDEND_W'(64'(up_data.rem) - trial);
      end
      data_in.q = {up_data.q[QUOT_W-2:0], hit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data = data_ff;
endmodule
`default_nettype wire

// ----- sv/thermistor_adc_to_temperature.sv -----
// Thermistor divider sample to temperature, beta equation in fixed point.
// req carries one converter code per item; rsp returns one item per request
// with the temperature in hundredths of a degree Celsius and a valid flag
// (cleared, with -273.15, for a code of zero or full scale).
// The block is a 54-stage pipeline: input register, normalization, 28 log2
// squaring stages (one fraction bit each, one 31x31 multiplier per lane),
// a ln2 scaling multiply, rounding, the T0 multiply, the denominator, an
// overflow check, 18 restoring-division stages (one quotient bit each) and
// the output register. Throughput is one item per clock while the receiver
// keeps rsp.ready high.
// Each stage holds its item until the next one has room, so when the
// receiver stalls the pipeline fills up and then deasserts req.ready;
// bubbles are squeezed out meanwhile. Nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets beta to 3950 K and T0 to
// 298.15 K. The csr port writes beta (index 0) or T0 (index 1) and should
// only be used while no item is in flight.
`default_nettype none
module thermistor_adc_to_temperature #(
   parameter int ADC_BITS = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   tat_req_if.sink req,
   tat_rsp_if.source rsp,
   input  wire logic csr_we,
   input  tat_pkg::csr_index_type csr_index,
   input  wire logic [15:0] csr_wdata
);
   import tat_pkg::*;

   localparam int EXP_W = $clog2(ADC_BITS);
   localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
   localparam int NLOG = LOG_FRAC;

   // Configuration and the constants derived from it.
   logic [13:0] beta_ff;
   logic [15:0] t0_ff;
   logic [20:0] hb_ff;
   logic [60:0] num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= BETA_RESET;
         t0_ff <= T0_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BETA: beta_ff <= csr_wdata[13:0];
            CSR_NOMINAL_TEMP: t0_ff <= csr_wdata;
            default: ;
         endcase
      end
      hb_ff <= 21'(beta_ff * 7'd100);
      num_ff <= {37'(hb_ff * t0_ff), 24'b0};
   end

   // Input register.
   logic s0_valid_ff, s0_ready;
   logic [ADC_BITS-1:0] code_ff;

   assign req.ready = ~s0_valid_ff | s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s0_valid_ff <= req.valid;
      end
      if (req.ready) begin
         code_ff <= req.adc_code;
      end
   end

   // Normalization: exponent and Q1.30 mantissa for code and FS - code.
   function automatic void normalize(input logic [ADC_BITS-1:0] x,
                                     output logic [MANT_W-1:0] m,
                                     output logic [ACC_W-1:0] acc);
      logic [EXP_W-1:0] e;
      e = '0;
      for (int i = 0; i < ADC_BITS; i++) begin
         if (x[i]) e = EXP_W'(i);
      end
      m = MANT_W'(MANT_W'(x) << (MANT_W - 1 - int'(e)));
      acc = ACC_W'(e) << LOG_FRAC;
   endfunction

   logic log_valid [0:NLOG];
   logic log_ready [0:NLOG];
   log_type log_data [0:NLOG];
   log_type s1_in;
   logic [ADC_BITS-1:0] rest;
   logic s1_valid_ff;
   log_type s1_ff;

   always_comb begin
      rest = FULL_SCALE - code_ff;
      s1_in.special = (code_ff == '0) || (code_ff == FULL_SCALE);
      normalize(code_ff, s1_in.m_c, s1_in.acc_c);
      normalize(rest, s1_in.m_r, s1_in.acc_r);
   end

   assign s0_ready = ~s1_valid_ff | log_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (s0_ready) begin
         s1_ff <= s1_in;
      end
   end

   assign log_valid[0] = s1_valid_ff;
   assign log_data[0] = s1_ff;

   for (genvar k = 0; k < NLOG; k++) begin : g_log
      tat_log2_step #(.BIT(LOG_FRAC - 1 - k)) u_step (
         .clock(clock), .reset(reset),
         .up_valid(log_valid[k]), .up_ready(log_ready[k]), .up_data(log_data[k]),
         .dn_valid(log_valid[k+1]), .dn_ready(log_ready[k+1]),
         .dn_data(log_data[k+1])
      );
   end

   // Difference of the logs times ln 2, by magnitude.
   logic mul_valid_ff, mul_ready;
   logic mul_special_ff, mul_neg_ff;
   logic [62:0] mul_prod_ff;
   logic signed [32:0] diff;
   logic [32:0] diff_mag;

   always_comb begin
      diff = $signed({1'b0, log_data[NLOG].acc_c}) - $signed({1'b0, log_data[NLOG].acc_r});
      diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
   end

   assign log_ready[NLOG] = ~mul_valid_ff | mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (log_ready[NLOG]) begin
         mul_valid_ff <= log_valid[NLOG];
      end
      if (log_ready[NLOG]) begin
         mul_special_ff <= log_data[NLOG].special;
         mul_neg_ff <= diff[32];
         mul_prod_ff <= 63'(diff_mag) * 63'(LN2_Q30);
      end
   end

   // Round the magnitude to Q.24 and restore the sign.
   logic ln_valid_ff, ln_ready;
   logic ln_special_ff;
   logic signed [30:0] ln24_ff;
   logic [63:0] ln_sum;
   logic [29:0] ln_mag;

   always_comb begin
      ln_sum = 64'(mul_prod_ff) + (64'(1) << 33);
      ln_mag = ln_sum[63:34];
   end

   assign mul_ready = ~ln_valid_ff | ln_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ln_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         ln_valid_ff <= mul_valid_ff;
      end
      if (mul_ready) begin
         ln_special_ff <= mul_special_ff;
         ln24_ff <= mul_neg_ff ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
      end
   end

   // T0 * ln(ratio).
   logic tm_valid_ff, tm_ready;
   logic tm_special_ff;
   logic signed [47:0] tm_prod_ff;

   assign ln_ready = ~tm_valid_ff | tm_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tm_valid_ff <= 1'b0;
      end else if (ln_ready) begin
         tm_valid_ff <= ln_valid_ff;
      end
      if (ln_ready) begin
         tm_special_ff <= ln_special_ff;
         tm_prod_ff <= $signed({1'b0, t0_ff}) * ln24_ff;
      end
   end

   // Denominator, saturation on a non-positive one, rounded dividend.
   logic dn_valid_ff, dn_ready;
   logic dn_special_ff, dn_sat_ff;
   logic [DEN_W-1:0] dn_den_ff;
   logic [DIVIDEND_W-1:0] dn_dividend_ff;
   logic signed [48:0] den;

   assign den = $signed(49'({hb_ff, 24'b0})) + 49'(tm_prod_ff);
   assign tm_ready = ~dn_valid_ff | dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (tm_ready) begin
         dn_valid_ff <= tm_valid_ff;
      end
      if (tm_ready) begin
         dn_special_ff <= tm_special_ff;
         dn_sat_ff <= den[48] | (den == '0);
         dn_den_ff <= den[DEN_W-1:0];
         dn_dividend_ff <= DIVIDEND_W'(num_ff) + DIVIDEND_W'(den[DEN_W-1:1]);
      end
   end

   // A quotient that needs more than 18 bits is far out of range.
   logic div_valid [0:QUOT_W];
   logic div_ready [0:QUOT_W];
   div_type div_data [0:QUOT_W];
   logic ov_valid_ff;
   div_type ov_ff, ov_in;

   always_comb begin
      ov_in.special = dn_special_ff;
      ov_in.sat = dn_sat_ff | ({2'b0, dn_dividend_ff} >= {dn_den_ff, 18'b0});
      ov_in.rem = dn_dividend_ff;
      ov_in.den = dn_den_ff;
      ov_in.q = '0;
   end

   assign dn_ready = ~ov_valid_ff | div_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_valid_ff <= 1'b0;
      end else if (dn_ready) begin
         ov_valid_ff <= dn_valid_ff;
      end
      if (dn_ready) begin
         ov_ff <= ov_in;
      end
   end

   assign div_valid[0] = ov_valid_ff;
   assign div_data[0] = ov_ff;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      tat_div_step #(.SHIFT(QUOT_W - 1 - k)) u_step (
         .clock(clock), .reset(reset),
         .up_valid(div_valid[k]), .up_ready(div_ready[k]), .up_data(div_data[k]),
         .dn_valid(div_valid[k+1]), .dn_ready(div_ready[k+1]),
         .dn_data(div_data[k+1])
      );
   end

   // Output register.
   logic out_valid_ff;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic tv_ff, tv_in;
   div_type fin;

   always_comb begin
      fin = div_data[QUOT_W];
      tv_in = 1'b1;
      if (fin.special) begin
         temp_in = OUT_COLD;
         tv_in = 1'b0;
      end else if (fin.sat || (fin.q > Q_MAX)) begin
         temp_in = OUT_MAX;
      end else begin
         temp_in = $signed(TEMP_W'(fin.q) - ZERO_C_CK);
      end
   end

   assign div_ready[QUOT_W] = ~out_valid_ff | rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (div_ready[QUOT_W]) begin
         out_valid_ff <= div_valid[QUOT_W];
      end
      if (div_ready[QUOT_W]) begin
         temp_ff <= temp_in;
         tv_ff <= tv_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.temp_centi_celsius = temp_ff;
   assign rsp.temp_valid = tv_ff;

   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp.valid)
      else $error("result offered right after reset");

   a_invalid_cold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.temp_valid |-> rsp.temp_centi_celsius == OUT_COLD)
      else $error("invalid item without the absolute-zero code");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.temp_centi_celsius <= OUT_MAX) &&
                    (rsp.temp_centi_celsius >= OUT_COLD))
      else $error("temperature outside its range");

   a_special_path: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && (req.adc_code == '0) |=> s1_in.special || !s0_valid_ff)
      else $error("zero code not flagged");
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tat_pkg::*;

   localparam int FULL_CODE = 4095;
   localparam int PIPE_DEPTH = 53;

   typedef struct {
      logic signed [16:0] temp;
      logic ok;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_BETA;
   logic [15:0] csr_wdata = '0;

   tat_req_if #(.ADC_BITS(12)) req ();
   tat_rsp_if rsp ();

   thermistor_adc_to_temperature #(.ADC_BITS(12)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [11:0] code_queue[$];
   reading_type expected_readings[$];
   logic [13:0] beta_k = BETA_RESET;
   logic [15:0] t0_ck = T0_RESET;
   int error_count = 0;
   int stall_hold = 0;       // long receiver hold-off, in cycles
   bit pattern_stall = 1'b0;
   int gap_left = 0;
   int burst_left = 0;
   bit sender_paused = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint log2_fixed(int unsigned x);
      int unsigned e;
      longint unsigned m;
      longint acc;
      e = 0;
      while (e < 31 && (x >> (e + 1)) != 0) e++;
      m = longint'(x) << (30 - e);
      acc = longint'(e) << 28;
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            acc += longint'(1) << i;
         end
      end
      return acc;
   endfunction

   function automatic reading_type convert_code(logic [11:0] code);
      reading_type r;
      longint d, prod, ln24, den;
      longint unsigned mag, num, q;
      bit neg;
      r.ok = 1'b1;
      if (code == 0 || code == FULL_CODE) begin
         r.temp = OUT_COLD;
         r.ok = 1'b0;
         return r;
      end
      d = log2_fixed(code) - log2_fixed(FULL_CODE - code);
      prod = d * 64'sd744261118;
      neg = prod < 0;
      mag = neg ? -prod : prod;
      mag = (mag + (64'd1 << 33)) >> 34;
      ln24 = neg ? -longint'(mag) : longint'(mag);
      num = (64'd100 * beta_k * t0_ck) << 24;
      den = (64'sd100 * beta_k * (64'sd1 << 24)) + longint'(t0_ck) * ln24;
      if (den <= 0) begin
         r.temp = OUT_MAX;
      end else begin
         q = (num + longint'(den) / 2) / longint'(den);
         if (q > 87315) r.temp = OUT_MAX;
         else r.temp = 17'(longint'(q) - 27315);
      end
      return r;
   endfunction

   // Driver: bursts and gaps; predicts each item as it is accepted.
   // The item on offer is always the head of the queue.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_readings.push_back(convert_code(req.adc_code));
            void'(code_queue.pop_front());
         end
         if (gap_left > 0) gap_left <= gap_left - 1;
         if (req.valid && !req.ready) begin
            req.valid <= 1'b1;
         end else if (sender_paused || code_queue.size() == 0) begin
            req.valid <= 1'b0;
         end else if (gap_left > 0) begin
            req.valid <= 1'b0;
         end else begin
            req.valid <= 1'b1;
            req.adc_code <= code_queue[0];
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Receiver stall pattern, with a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp.ready <= 1'b0;
         end else if (pattern_stall) begin
            rsp.ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected item: temp_centi_celsius=%0d", rsp.temp_centi_celsius);
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp.temp_centi_celsius !== want.temp) begin
               $error("temp_centi_celsius expected %0d actual %0d",
                  want.temp, rsp.temp_centi_celsius);
               error_count++;
            end
            if (rsp.temp_valid !== want.ok) begin
               $error("temp_valid expected %0b actual %0b", want.ok, rsp.temp_valid);
               error_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (code_queue.size() != 0 || req.valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BETA) beta_k = value[13:0];
      else t0_ck = value;
      @(posedge clock);
   endtask

   task automatic add_random_codes(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) code_queue.push_back($urandom_range(0, 3));
         else if (pick == 1) code_queue.push_back($urandom_range(4092, 4095));
         else code_queue.push_back(12'($urandom));
      end
   endtask

   initial begin
      logic [13:0] betas[4] = '{14'd1000, 14'd10000, 14'd0, 14'h3FFF};
      logic [15:0] temps[4] = '{16'd27315, 16'd37315, 16'hFFFF, 16'd1};
      req.valid = 1'b0;
      req.adc_code = '0;
      rsp.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, the two dead codes, mid scale, single bits.
      code_queue = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2, 12'd4093, 12'd2047,
                     12'd2048, 12'd1000, 12'd3000, 12'hAAA, 12'h555};
      for (int b = 0; b < 12; b++) code_queue.push_back(12'(1 << b));
      wait_drained();

      // Long receiver hold-off while the sender keeps offering items.
      add_random_codes(150);
      @(posedge clock);
      stall_hold <= 200;
      wait_drained();

      pattern_stall = 1'b1;
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(CSR_BETA, {2'b00, betas[phase]});
         write_reg(CSR_NOMINAL_TEMP, temps[3 - phase]);
         add_random_codes(60);
         wait_drained();
         write_reg(CSR_NOMINAL_TEMP, temps[phase]);
         add_random_codes(40);
         // Pause the sender until everything issued so far has come back.
         while (code_queue.size() > 20) @(posedge clock);
         sender_paused = 1'b1;
         while (req.valid && !req.ready) @(posedge clock);
         while (expected_readings.size() != 0) @(posedge clock);
         sender_paused = 1'b0;
         wait_drained();
      end
      write_reg(CSR_BETA, {2'b00, 14'($urandom_range(1000, 10000))});
      write_reg(CSR_NOMINAL_TEMP, 16'($urandom_range(27315, 37315)));
      pattern_stall = 1'b0;
      add_random_codes(50);
      wait_drained();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ----- thermistor_adc_to_temperature.f -----
sv/tat_pkg.sv
sv/tat_if.sv
sv/tat_log2_step.sv
sv/tat_div_step.sv
sv/thermistor_adc_to_temperature.sv
verif/testbench.sv
